// File: sv/epou_pkg.sv
package epou_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned AddrW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned RunW       = 2;

  localparam logic [ByteW-1:0] ByteZero   = 8'h00;
  localparam logic [ByteW-1:0] ByteEscape = 8'h03;

  localparam logic CmdOffset = 1'b0;
  localparam logic CmdByte   = 1'b1;

  typedef struct packed {
    logic [IndexW-1:0] entry_index;
    logic [WordW-1:0]  payload_offset;
    logic              past_end;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } octl_t;

  typedef struct packed {
    logic ready;
    logic pend_valid;
  } ostat_t;

endpackage

// File: sv/epou_entry_ram.sv
module epou_entry_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [epou_pkg::AddrW-1:0]       waddr_i,
  input  logic [epou_pkg::WordW-1:0]       wdata_i,
  input  logic                             re_i,
  input  logic [epou_pkg::AddrW-1:0]       raddr_i,
  output logic [epou_pkg::WordW-1:0]       rdata_o
);

  logic [epou_pkg::WordW-1:0] mem_q [epou_pkg::MaxEntries];
  logic [epou_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/epou_out_stage.sv
module epou_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  epou_pkg::octl_t   ctl_i,
  input  epou_pkg::result_t res_i,
  output epou_pkg::ostat_t  stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output epou_pkg::result_t out_res_o,
  output logic              out_last_o
);

  logic              pend_valid_q, pend_valid_d;
  epou_pkg::result_t pend_res_q, pend_res_d;
  logic              out_valid_q, out_valid_d;
  epou_pkg::result_t out_res_q, out_res_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign stat_o.ready = !pend_valid_q || out_free;
  assign stat_o.pend_valid = pend_valid_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_res_d   = pend_res_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    out_last_d   = out_last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.push) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_res_d   = pend_res_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_res_d   = res_i;
    end else if (ctl_i.flush && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_res_d    = pend_res_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> stat_o.ready) else $error("push while stage full");

  a_flush_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.flush |-> stat_o.ready) else $error("flush while stage full");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.push && ctl_i.flush)) else $error("push and flush together");

  a_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push && pend_valid_q |=> out_valid_o && !out_last_o)
    else $error("spilled word not marked as inner word");

endmodule

// File: sv/entry_point_offset_unescaper_top.sv
// Channel  | Handshake                   | Word
// ---------+-----------------------------+-----------------------------------------------
// in       | in_valid_i / in_stall_o     | command_i, value_i, end_of_nal_i
// out      | out_valid_o / out_stall_i   | entry_index_o, payload_offset_o, past_end_o,
//          |                             | last_of_run_o
// cfg      | cfg_we_i                    | cfg_wdata_i (first_offset)
//
// An offset append, or a first byte that does not end its NAL, is taken in the idle state alone.
// A consumed byte passes accept, table read, compare and close, with one more compare per match;
// end of NAL adds a second read and compare when a byte was held, one fill step per unmatched
// entry and one clearing step. Each compare waits on the registered table read.
// Reset clears all counters and the output stage at once; the table needs no clearing.
// A stalled output holds the engine through a one-word pending stage plus the output register.
module entry_point_offset_unescaper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [epou_pkg::WordW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [epou_pkg::WordW-1:0]          value_i,
  input  logic                                end_of_nal_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [epou_pkg::IndexW-1:0]         entry_index_o,
  output logic [epou_pkg::WordW-1:0]          payload_offset_o,
  output logic                                past_end_o,
  output logic                                last_of_run_o
);

  typedef enum logic [2:0] {
    StIdle,
    StOrigin,
    StCompare,
    StFill,
    StDone
  } state_e;

  state_e                        state_q, state_d;
  logic [epou_pkg::WordW-1:0]    first_offset_q, first_offset_d;
  logic [epou_pkg::CntW-1:0]     entry_count_q, entry_count_d;
  logic [epou_pkg::CntW-1:0]     next_entry_q, next_entry_d;
  logic [epou_pkg::WordW-1:0]    raw_count_q, raw_count_d;
  logic [epou_pkg::WordW-1:0]    payload_count_q, payload_count_d;
  logic [epou_pkg::WordW-1:0]    raw_origin_q, raw_origin_d;
  logic [epou_pkg::WordW-1:0]    payload_origin_q, payload_origin_d;
  logic                          origin_found_q, origin_found_d;
  logic [epou_pkg::RunW-1:0]     zero_run_q, zero_run_d;
  logic [epou_pkg::ByteW-1:0]    held_byte_q, held_byte_d;
  logic                          held_valid_q, held_valid_d;
  logic [epou_pkg::ByteW-1:0]    cur_byte_q, cur_byte_d;
  logic                          has_next_q, has_next_d;
  logic                          pass2_q, pass2_d;
  logic                          eon_q, eon_d;

  logic                          in_acc;
  logic                          has_entry;
  logic                          hit;
  logic                          drop_byte;
  logic [epou_pkg::CntW-1:0]     nxt_ptr;
  logic [epou_pkg::WordW-1:0]    dist_raw;
  logic [epou_pkg::WordW-1:0]    dist_pay;

  logic                          ram_we;
  logic                          ram_re;
  logic [epou_pkg::AddrW-1:0]    ram_raddr;
  logic [epou_pkg::WordW-1:0]    ram_rdata;

  epou_pkg::octl_t               octl;
  epou_pkg::ostat_t              ostat;
  epou_pkg::result_t             res;
  epou_pkg::result_t             out_res;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign dist_raw   = raw_count_q - raw_origin_q;
  assign dist_pay   = payload_count_q - payload_origin_q;
  assign has_entry  = next_entry_q < entry_count_q;
  assign hit        = origin_found_q && has_entry && (dist_raw == ram_rdata);
  assign nxt_ptr    = next_entry_q + epou_pkg::CntW'(1);
  assign drop_byte  = (zero_run_q >= epou_pkg::RunW'(2)) && (cur_byte_q == epou_pkg::ByteEscape)
                      && !(has_next_q && (held_byte_q > epou_pkg::ByteEscape));
  assign ram_we     = in_acc && (command_i == epou_pkg::CmdOffset)
                      && (entry_count_q < epou_pkg::CntW'(epou_pkg::MaxEntries));

  assign res.entry_index    = epou_pkg::IndexW'(next_entry_q);
  assign res.payload_offset = dist_pay;
  assign res.past_end       = (state_q == StFill);

  always_comb begin
    state_d          = state_q;
    first_offset_d   = first_offset_q;
    entry_count_d    = entry_count_q;
    next_entry_d     = next_entry_q;
    raw_count_d      = raw_count_q;
    payload_count_d  = payload_count_q;
    raw_origin_d     = raw_origin_q;
    payload_origin_d = payload_origin_q;
    origin_found_d   = origin_found_q;
    zero_run_d       = zero_run_q;
    held_byte_d      = held_byte_q;
    held_valid_d     = held_valid_q;
    cur_byte_d       = cur_byte_q;
    has_next_d       = has_next_q;
    pass2_d          = pass2_q;
    eon_d            = eon_q;
    ram_re           = 1'b0;
    ram_raddr        = next_entry_q[epou_pkg::AddrW-1:0];
    octl             = '0;

    if (cfg_we_i) begin
      first_offset_d = cfg_wdata_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (command_i == epou_pkg::CmdOffset) begin
            if (ram_we) begin
              entry_count_d = entry_count_q + epou_pkg::CntW'(1);
            end
          end else begin
            held_byte_d  = value_i[epou_pkg::ByteW-1:0];
            cur_byte_d   = held_valid_q ? held_byte_q : value_i[epou_pkg::ByteW-1:0];
            has_next_d   = held_valid_q;
            pass2_d      = held_valid_q && end_of_nal_i;
            eon_d        = end_of_nal_i;
            held_valid_d = 1'b1;
            if (held_valid_q || end_of_nal_i) begin
              state_d = StOrigin;
            end
          end
        end
      end
      StOrigin: begin
        if (!origin_found_q && (payload_count_q == first_offset_q)) begin
          raw_origin_d     = raw_count_q;
          payload_origin_d = payload_count_q;
          origin_found_d   = 1'b1;
        end
        ram_re  = 1'b1;
        state_d = StCompare;
      end
      StCompare: begin
        if (hit) begin
          if (ostat.ready) begin
            octl.push    = 1'b1;
            next_entry_d = nxt_ptr;
            ram_re       = 1'b1;
            ram_raddr    = nxt_ptr[epou_pkg::AddrW-1:0];
          end
        end else begin
          raw_count_d = raw_count_q + epou_pkg::WordW'(1);
          if (drop_byte) begin
            zero_run_d = '0;
          end else begin
            payload_count_d = payload_count_q + epou_pkg::WordW'(1);
            if (cur_byte_q == epou_pkg::ByteZero) begin
              zero_run_d = (zero_run_q >= epou_pkg::RunW'(2)) ? epou_pkg::RunW'(2)
                                                              : zero_run_q + epou_pkg::RunW'(1);
            end else begin
              zero_run_d = '0;
            end
          end
          if (pass2_q) begin
            cur_byte_d = held_byte_q;
            has_next_d = 1'b0;
            pass2_d    = 1'b0;
            state_d    = StOrigin;
          end else if (eon_q) begin
            state_d = StFill;
          end else begin
            state_d = StDone;
          end
        end
      end
      StFill: begin
        if (has_entry) begin
          if (ostat.ready) begin
            octl.push    = 1'b1;
            next_entry_d = nxt_ptr;
          end
        end else begin
          entry_count_d    = '0;
          next_entry_d     = '0;
          raw_count_d      = '0;
          payload_count_d  = '0;
          raw_origin_d     = '0;
          payload_origin_d = '0;
          origin_found_d   = 1'b0;
          zero_run_d       = '0;
          held_byte_d      = '0;
          held_valid_d     = 1'b0;
          state_d          = StDone;
        end
      end
      StDone: begin
        if (!ostat.pend_valid) begin
          state_d = StIdle;
        end else if (ostat.ready) begin
          octl.flush = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      first_offset_q   <= '0;
      entry_count_q    <= '0;
      next_entry_q     <= '0;
      raw_count_q      <= '0;
      payload_count_q  <= '0;
      raw_origin_q     <= '0;
      payload_origin_q <= '0;
      origin_found_q   <= 1'b0;
      zero_run_q       <= '0;
      held_byte_q      <= '0;
      held_valid_q     <= 1'b0;
      cur_byte_q       <= '0;
      has_next_q       <= 1'b0;
      pass2_q          <= 1'b0;
      eon_q            <= 1'b0;
    end else begin
      state_q          <= state_d;
      first_offset_q   <= first_offset_d;
      entry_count_q    <= entry_count_d;
      next_entry_q     <= next_entry_d;
      raw_count_q      <= raw_count_d;
      payload_count_q  <= payload_count_d;
      raw_origin_q     <= raw_origin_d;
      payload_origin_q <= payload_origin_d;
      origin_found_q   <= origin_found_d;
      zero_run_q       <= zero_run_d;
      held_byte_q      <= held_byte_d;
      held_valid_q     <= held_valid_d;
      cur_byte_q       <= cur_byte_d;
      has_next_q       <= has_next_d;
      pass2_q          <= pass2_d;
      eon_q            <= eon_d;
    end
  end

  epou_entry_ram u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_count_q[epou_pkg::AddrW-1:0]),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  epou_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (octl),
    .res_i       (res),
    .stat_o      (ostat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_of_run_o)
  );

  assign entry_index_o    = out_res.entry_index;
  assign payload_offset_o = out_res.payload_offset;
  assign past_end_o       = out_res.past_end;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_entry_q <= entry_count_q) else $error("entry pointer beyond table fill");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_index_o)
      && $stable(payload_offset_o) && $stable(past_end_o) && $stable(last_of_run_o))
    else $error("stalled word changed");

  a_run_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q <= epou_pkg::RunW'(2)) else $error("zero run beyond two");

endmodule

// File: test/entry_point_offset_unescaper_checker.sv
`timescale 1ns / 100ps

module entry_point_offset_unescaper_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [epou_pkg::WordW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [epou_pkg::WordW-1:0]          value_i,
  input  logic                                end_of_nal_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [epou_pkg::IndexW-1:0]         entry_index_o,
  input  logic [epou_pkg::WordW-1:0]          payload_offset_o,
  input  logic                                past_end_o,
  input  logic                                last_of_run_o,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_count_o,
  output int unsigned                         checked_count_o
);

  typedef struct packed {
    logic [epou_pkg::IndexW-1:0] entry_index;
    logic [epou_pkg::WordW-1:0]  payload_offset;
    logic                        past_end;
    logic                        last_of_run;
  } converted_word_t;

  converted_word_t converted_q[$];

  logic [epou_pkg::WordW-1:0] first_offset;
  logic [epou_pkg::WordW-1:0] offset_table [epou_pkg::MaxEntries];
  logic [epou_pkg::CntW-1:0]  entry_count;
  logic [epou_pkg::CntW-1:0]  next_entry;
  logic [epou_pkg::WordW-1:0] raw_count;
  logic [epou_pkg::WordW-1:0] payload_count;
  logic [epou_pkg::WordW-1:0] raw_origin;
  logic [epou_pkg::WordW-1:0] payload_origin;
  logic                       origin_found;
  logic [epou_pkg::RunW-1:0]  zero_run;
  logic [epou_pkg::ByteW-1:0] held_byte;
  logic                       held_valid;
  int unsigned                run_results;

  function automatic void clear_nal_state();
    entry_count    = '0;
    next_entry     = '0;
    raw_count      = '0;
    payload_count  = '0;
    raw_origin     = '0;
    payload_origin = '0;
    origin_found   = 1'b0;
    zero_run       = '0;
    held_byte      = '0;
    held_valid     = 1'b0;
  endfunction

  function automatic void emit_offset(logic past);
    converted_word_t w;
    w.entry_index    = next_entry[epou_pkg::IndexW-1:0];
    w.payload_offset = payload_count - payload_origin;
    w.past_end       = past;
    w.last_of_run    = 1'b0;
    converted_q.push_back(w);
    next_entry++;
    run_results++;
  endfunction

  function automatic void consume_byte(logic [epou_pkg::ByteW-1:0] c, logic has_next,
                                       logic [epou_pkg::ByteW-1:0] nxt);
    if (!origin_found && payload_count == first_offset) begin
      raw_origin     = raw_count;
      payload_origin = payload_count;
      origin_found   = 1'b1;
    end
    while (origin_found && next_entry < entry_count &&
           (raw_count - raw_origin) == offset_table[next_entry[epou_pkg::AddrW-1:0]])
      emit_offset(1'b0);
    if (zero_run >= 2 && c == epou_pkg::ByteEscape
        && !(has_next && nxt > epou_pkg::ByteEscape)) begin
      zero_run = '0;
      raw_count++;
    end else begin
      if (c == epou_pkg::ByteZero) zero_run = (zero_run >= 2) ? 2'd2 : zero_run + 2'd1;
      else zero_run = '0;
      raw_count++;
      payload_count++;
    end
  endfunction

  function automatic void apply_word(logic cmd, logic [epou_pkg::WordW-1:0] value, logic eon);
    logic [epou_pkg::ByteW-1:0] b;
    converted_word_t            tail;
    run_results = 0;
    b = value[epou_pkg::ByteW-1:0];
    if (cmd == epou_pkg::CmdOffset) begin
      if (entry_count < epou_pkg::MaxEntries) begin
        offset_table[entry_count[epou_pkg::AddrW-1:0]] = value;
        entry_count++;
      end
    end else begin
      if (held_valid) consume_byte(held_byte, 1'b1, b);
      if (eon) begin
        consume_byte(b, 1'b0, '0);
        while (next_entry < entry_count) emit_offset(1'b1);
        clear_nal_state();
      end else begin
        held_byte  = b;
        held_valid = 1'b1;
      end
      if (run_results != 0) begin
        tail = converted_q.pop_back();
        tail.last_of_run = 1'b1;
        converted_q.push_back(tail);
      end
    end
  endfunction

  function automatic void compare_field(string name, logic [epou_pkg::WordW-1:0] want,
                                        logic [epou_pkg::WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic void check_word();
    converted_word_t want;
    if (converted_q.size() == 0) begin
      $error("result word with none expected: entry_index %0d, payload_offset 0x%0h",
             entry_index_o, payload_offset_o);
      fail_count_o++;
    end else begin
      want = converted_q.pop_front();
      compare_field("entry_index", want.entry_index, entry_index_o);
      compare_field("payload_offset", want.payload_offset, payload_offset_o);
      compare_field("past_end", want.past_end, past_end_o);
      compare_field("last_of_run", want.last_of_run, last_of_run_o);
      checked_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_offset = '0;
      clear_nal_state();
      converted_q.delete();
      fail_count_o    = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_we_i) first_offset = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) apply_word(command_i, value_i, end_of_nal_i);
      if (out_valid_o && !out_stall_i) check_word();
    end
    pending_count_o = converted_q.size();
  end

endmodule

// File: test/tb_entry_point_offset_unescaper_top.sv
`timescale 1ns / 100ps

module tb_entry_point_offset_unescaper_top;

  localparam int unsigned SettleCycles = 200;
  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned MaxGap       = 40;
  localparam int unsigned PhaseWords   = 5;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [epou_pkg::WordW-1:0]  cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic                        command_i    = epou_pkg::CmdOffset;
  logic [epou_pkg::WordW-1:0]  value_i      = '0;
  logic                        end_of_nal_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [epou_pkg::IndexW-1:0] entry_index_o;
  logic [epou_pkg::WordW-1:0]  payload_offset_o;
  logic                        past_end_o;
  logic                        last_of_run_o;

  int unsigned fail_count_o;
  int unsigned pending_count_o;
  int unsigned checked_count_o;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned word_count  = 0;
  int unsigned nal_count   = 0;
  int unsigned idle_cycles = 0;

  entry_point_offset_unescaper_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .value_i          (value_i),
    .end_of_nal_i     (end_of_nal_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_index_o    (entry_index_o),
    .payload_offset_o (payload_offset_o),
    .past_end_o       (past_end_o),
    .last_of_run_o    (last_of_run_o)
  );

  entry_point_offset_unescaper_checker checker_i (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("entry_point_offset_unescaper_top test failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic cmd, logic [epou_pkg::WordW-1:0] value, logic eon);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    value_i      <= value;
    end_of_nal_i <= eon;
    do @(posedge clk_i); while (in_stall_o);
    word_count++;
    if (cmd == epou_pkg::CmdByte && eon) nal_count++;
  endtask

  // drop valid, wait for every expected word, then let the block finish any work that produces no word
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_count_o != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_first_offset(logic [epou_pkg::WordW-1:0] v);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [epou_pkg::WordW-1:0] stream_byte();
    int unsigned                r;
    logic [epou_pkg::ByteW-1:0] b;
    logic [epou_pkg::WordW-1:0] hi;
    r = $urandom_range(99);
    if (r < 40) b = epou_pkg::ByteZero;
    else if (r < 65) b = epou_pkg::ByteEscape;
    else if (r < 75) b = epou_pkg::ByteW'($urandom_range(1, 4));
    else b = epou_pkg::ByteW'($urandom_range(0, 255));
    hi = ($urandom_range(4) == 0) ? $urandom : '0;
    return {hi[epou_pkg::WordW-1:epou_pkg::ByteW], b};
  endfunction

  task automatic append_entry(int unsigned off);
    send_word(epou_pkg::CmdOffset, ($urandom_range(9) == 0) ? $urandom : off,
              $urandom_range(4) == 0);
  endtask

  task automatic send_nal();
    logic [epou_pkg::WordW-1:0] stream [8];
    int unsigned n_bytes, n_entries, n_early, split, off;
    n_bytes   = $urandom_range(1, 8);
    n_entries = $urandom_range(0, 4);
    n_early   = (n_bytes > 1) ? $urandom_range(0, n_entries) : n_entries;
    split     = (n_bytes > 1) ? $urandom_range(0, n_bytes - 2) : 0;
    off       = $urandom_range(0, 2);
    for (int i = 0; i < n_bytes; i++) stream[i] = stream_byte();
    for (int k = 0; k < n_early; k++) begin
      append_entry(off);
      off += $urandom_range(0, 3);
    end
    for (int i = 0; i < n_bytes; i++) begin
      send_word(epou_pkg::CmdByte, stream[i], i == n_bytes - 1);
      if (i == split && n_bytes > 1) begin
        for (int k = n_early; k < n_entries; k++) begin
          append_entry(off);
          off += $urandom_range(0, 3);
        end
      end
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    logic        cmd;
    n = $urandom_range(1, 4);
    repeat (n) begin
      cmd = 1'($urandom_range(0, 1));
      send_word(cmd, $urandom,
                (cmd == epou_pkg::CmdOffset) ? ($urandom_range(0, 1) == 1)
                                             : ($urandom_range(5) == 0));
    end
    send_word(epou_pkg::CmdByte, $urandom, 1'b1);
  endtask

  // one append past a full table, then a short stream
  task automatic send_full_table();
    int unsigned off;
    off = 0;
    repeat (epou_pkg::MaxEntries + 1) begin
      send_word(epou_pkg::CmdOffset, off, 1'b0);
      off += $urandom_range(0, 1);
    end
    send_word(epou_pkg::CmdByte, stream_byte(), 1'b0);
    send_word(epou_pkg::CmdByte, stream_byte(), 1'b1);
  endtask

  initial begin
    int unsigned                phase_words;
    logic [epou_pkg::WordW-1:0] phase_offset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_first_offset('0);
    send_word(epou_pkg::CmdOffset, 32'd0, 1'b0);
    send_word(epou_pkg::CmdOffset, 32'd2, 1'b0);
    send_word(epou_pkg::CmdOffset, 32'd2, 1'b0);
    send_word(epou_pkg::CmdOffset, 32'hFFFF_FFFF, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0003, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0001, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0003, 1'b0);
    send_word(epou_pkg::CmdByte, 32'hABCD_EF04, 1'b0);
    send_word(epou_pkg::CmdOffset, 32'd9, 1'b1);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h0000_0000, 1'b0);
    send_word(epou_pkg::CmdByte, 32'hFFFF_FF03, 1'b1);
    send_word(epou_pkg::CmdByte, 32'h0000_00FF, 1'b1);
    send_word(epou_pkg::CmdOffset, 32'd0, 1'b0);
    send_word(epou_pkg::CmdByte, 32'h5A5A_A57F, 1'b1);

    set_first_offset(32'd2);
    stall_pct = 75;
    send_full_table();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          phase_offset = $urandom_range(0, 3);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          phase_offset = 32'hFFFF_FFFF;
          idle_pct = 75;
          stall_pct = 0;
        end
        2: begin
          phase_offset = $urandom_range(1, 5);
          idle_pct = 0;
          stall_pct = 75;
        end
        default: begin
          phase_offset = 32'h0;
          idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      set_first_offset(phase_offset);
      phase_words = word_count;
      while (word_count - phase_words < PhaseWords) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_nal();
      end
    end

    drain_block();
    $display("Checked %0d result words from %0d input words in %0d NAL units,",
             checked_count_o, word_count, nal_count);
    $display("over six first_offset settings, a full entry table and four idle/stall mixes.");
    if (fail_count_o == 0 && pending_count_o == 0) begin
      $display("entry_point_offset_unescaper_top test passed");
    end else begin
      $display("entry_point_offset_unescaper_top test failed");
    end
    $finish;
  end

endmodule
